// ===== src/step_sequencer_channel_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the step sequencer channel
// Short forms for clocked checks with a synchronous, active-low reset.
// ----------------------------------------------------------------------------
`ifndef STEP_SEQUENCER_CHANNEL_MACROS_SVH
`define STEP_SEQUENCER_CHANNEL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSC_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ssc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssc_pkg
// Types, codes and sizes shared by the step sequencer channel.
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

    // Pattern storage sizes.
    localparam int NUM_STEPS = 32;
    localparam int NUM_LANES = 3;
    localparam int OUT_LANES = 3;
    localparam int STEP_W    = $clog2(NUM_STEPS);
    localparam int CNT_W     = $clog2(NUM_STEPS + 1);

    // Field widths fixed by the stream formats.
    localparam int LEVEL_W     = 16;
    localparam int FIELD_POS_W = 5;
    localparam int SPLIT_W     = 5;
    localparam int STEPS_W     = 6;
    localparam int REP_W       = 7;
    localparam int RATE_W      = 4;
    localparam int DIR_W       = 2;
    localparam int LANE_SEL_W  = 2;
    localparam int DIV_W       = 4;
    localparam int ADV_W       = 5;

    // Signed play position, wide enough for the transient values of one advance.
    localparam int POS_W = ((STEP_W > SPLIT_W) ? STEP_W : SPLIT_W) + 2;
    localparam logic signed [POS_W-1:0] POS_ONE  = POS_W'(1);
    localparam logic signed [POS_W-1:0] POS_ZERO = POS_W'(0);

    // Bus widths.
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 56;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = 3;

    // Item kinds carried in tuser.
    typedef enum logic {
        FUNC_TICK  = 1'b0,
        FUNC_WRITE = 1'b1
    } t_func;

    // Register map, one word per register.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_RATE  = 3'd0,
        REG_DIR   = 3'd1,
        REG_STEPS = 3'd2,
        REG_SPLIT = 3'd3,
        REG_REP1  = 3'd4,
        REG_REP2  = 3'd5
    } t_reg_idx;

    // Play directions; the remaining code behaves as ping-pong.
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_BWD  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_PING = 2'd2;

    // Clock rate modes.
    localparam logic [RATE_W-1:0] MODE_DIV_LAST  = 4'd3;
    localparam logic [RATE_W-1:0] MODE_X1        = 4'd4;
    localparam logic [RATE_W-1:0] MODE_MUL_FIRST = 4'd5;
    localparam logic [RATE_W-1:0] MODE_MUL_LAST  = 4'd8;
    localparam logic [ADV_W-1:0]  DIV_MAX        = 5'd16;
    localparam logic [ADV_W-1:0]  MAX_ADV        = 5'd16;

    // Register reset values.
    localparam logic [RATE_W-1:0]  RATE_RST  = MODE_X1;
    localparam logic [DIR_W-1:0]   DIR_RST   = DIR_FWD;
    localparam logic [STEPS_W-1:0] STEPS_RST = 6'd32;
    localparam logic [SPLIT_W-1:0] SPLIT_RST = 5'd16;
    localparam logic [REP_W-1:0]   REP_RST   = 7'd1;

    // Stored levels are offset binary: the sign bit is flipped on write.
    localparam logic [LEVEL_W-1:0] LEVEL_FLIP = 16'h8000;
    localparam int unsigned        VOLT_STEP  = 13107;

    // Level a lane holds until its entry is first written.
    function automatic logic [LEVEL_W-1:0] lane_reset_level(input int unsigned lane);
        logic [31:0] v;
        v = 32'(VOLT_STEP) * 32'(lane + 1);
        if (v > 32'hFFFF) begin
            return 16'hFFFF;
        end
        return v[LEVEL_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/step_sequencer_channel.sv =====
// An accepted transaction passes through S_PROC, S_ADV, S_CLAMP and S_LOAD, and then its
// result is registered; S_ADV makes N advances (0, 1, 2, 4, 8 or 16). A new item is taken only when idle.
// The single advance unit moves the play position one step per cycle, followed
// by one registered read of the three pattern memories.
// Reset (synchronous, active low) restores the registers, play state and the test
// pattern at once, through per-entry valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
// step_sequencer_channel
// One channel of a clocked step sequencer with clock divider and multiplier,
// two-section forward/backward play, ping-pong play and a writable pattern.
// ----------------------------------------------------------------------------
`default_nettype none

`include "step_sequencer_channel_macros.svh"

module step_sequencer_channel (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input stream.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [0] clock_high, [1] reset_high, [6:2] write_step, [8:7] write_lane,
    // [24:9] write_value, [31:25] zero
    input  logic [ssc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // [0] func
    input  logic [0:0]                           s_axis_tuser,
    // Result stream.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [4:0] current_position, [5] second_section_active, [21:6] level_a,
    // [37:22] level_b, [53:38] level_c, [55:54] zero
    output logic [ssc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ssc_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [ssc_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [ssc_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROC,
        S_ADV,
        S_CLAMP,
        S_LOAD
    } t_state;

    // Configuration registers.
    logic [ssc_pkg::RATE_W-1:0]  r_cfg_rate;
    logic [ssc_pkg::DIR_W-1:0]   r_cfg_dir;
    logic [ssc_pkg::STEPS_W-1:0] r_cfg_steps;
    logic [ssc_pkg::SPLIT_W-1:0] r_cfg_split;
    logic [ssc_pkg::REP_W-1:0]   r_cfg_rep1;
    logic [ssc_pkg::REP_W-1:0]   r_cfg_rep2;
    logic                        w_cfg_we;
    ssc_pkg::t_reg_idx           w_cfg_idx;

    // Sequencer state.
    t_state                            r_state, n_state;
    logic signed [ssc_pkg::POS_W-1:0]  r_position, n_position;
    logic                              r_up, n_up;
    logic [ssc_pkg::DIV_W-1:0]         r_div_cnt, n_div_cnt;
    logic [ssc_pkg::REP_W-1:0]         r_frc, n_frc;
    logic [ssc_pkg::REP_W-1:0]         r_src, n_src;
    logic                              r_in_second, n_in_second;
    logic                              r_prev_clk, n_prev_clk;
    logic                              r_prev_rst, n_prev_rst;
    logic [ssc_pkg::ADV_W-1:0]         r_adv_left, n_adv_left;

    // Captured input item.
    ssc_pkg::t_func                    r_in_func, n_in_func;
    logic                              r_in_clk, n_in_clk;
    logic                              r_in_rst, n_in_rst;
    logic [ssc_pkg::SPLIT_W-1:0]       r_in_step, n_in_step;
    logic [ssc_pkg::LANE_SEL_W-1:0]    r_in_lane, n_in_lane;
    logic [ssc_pkg::LEVEL_W-1:0]       r_in_value, n_in_value;

    // Output register.
    logic                                               r_out_valid, n_out_valid;
    logic [ssc_pkg::FIELD_POS_W-1:0]                    r_out_pos, n_out_pos;
    logic                                               r_out_sec, n_out_sec;
    logic [ssc_pkg::OUT_LANES-1:0][ssc_pkg::LEVEL_W-1:0] r_out_level, n_out_level;

    // Effective step count, split point and derived signed bounds.
    logic [ssc_pkg::CNT_W-1:0]         w_cnt;
    logic [ssc_pkg::SPLIT_W-1:0]       w_split;
    logic signed [ssc_pkg::POS_W-1:0]  w_cnt_s;
    logic signed [ssc_pkg::POS_W-1:0]  w_last_s;
    logic signed [ssc_pkg::POS_W-1:0]  w_split_s;

    // Edge detection and clock rate handling.
    logic                              w_clk_edge;
    logic                              w_rst_edge;
    logic [ssc_pkg::DIV_W-1:0]         w_div_base;
    logic [ssc_pkg::ADV_W-1:0]         w_div_inc;
    logic [ssc_pkg::ADV_W-1:0]         w_div_limit;
    logic [ssc_pkg::DIV_W-1:0]         w_div_next;
    logic [ssc_pkg::ADV_W-1:0]         w_adv_num;

    // Shared advance unit.
    logic signed [ssc_pkg::POS_W-1:0]  w_inc;
    logic signed [ssc_pkg::POS_W-1:0]  w_dec;
    logic [ssc_pkg::REP_W:0]           w_fc;
    logic [ssc_pkg::REP_W:0]           w_sc;
    logic signed [ssc_pkg::POS_W-1:0]  a_pos;
    logic                              a_up;
    logic [ssc_pkg::REP_W-1:0]         a_frc;
    logic [ssc_pkg::REP_W-1:0]         a_src;
    logic                              a_in_second;

    // Clamp and pattern memory access.
    logic signed [ssc_pkg::POS_W-1:0]  w_clamp_pos;
    logic [ssc_pkg::STEP_W-1:0]        w_rd_addr;
    logic [ssc_pkg::STEP_W-1:0]        w_wr_addr;
    logic                              w_wr_item;
    wire  [ssc_pkg::NUM_LANES-1:0][ssc_pkg::LEVEL_W-1:0] w_lane_level;
    wire  [ssc_pkg::OUT_LANES-1:0][ssc_pkg::LEVEL_W-1:0] w_out_level;

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------

    // Writes complete in the access cycle; the port never waits.
    assign pready    = 1'b1;
    assign w_cfg_we  = psel & penable & pwrite & pready;
    assign w_cfg_idx = ssc_pkg::t_reg_idx'(paddr[ssc_pkg::APB_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rate  <= ssc_pkg::RATE_RST;
            r_cfg_dir   <= ssc_pkg::DIR_RST;
            r_cfg_steps <= ssc_pkg::STEPS_RST;
            r_cfg_split <= ssc_pkg::SPLIT_RST;
            r_cfg_rep1  <= ssc_pkg::REP_RST;
            r_cfg_rep2  <= ssc_pkg::REP_RST;
        end else if (w_cfg_we) begin
            unique case (w_cfg_idx)
                ssc_pkg::REG_RATE:  r_cfg_rate  <= pwdata[ssc_pkg::RATE_W-1:0];
                ssc_pkg::REG_DIR:   r_cfg_dir   <= pwdata[ssc_pkg::DIR_W-1:0];
                ssc_pkg::REG_STEPS: r_cfg_steps <= pwdata[ssc_pkg::STEPS_W-1:0];
                ssc_pkg::REG_SPLIT: r_cfg_split <= pwdata[ssc_pkg::SPLIT_W-1:0];
                ssc_pkg::REG_REP1:  r_cfg_rep1  <= pwdata[ssc_pkg::REP_W-1:0];
                ssc_pkg::REG_REP2:  r_cfg_rep2  <= pwdata[ssc_pkg::REP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read-back of the addressed register; unused addresses read as zero.
    always_comb begin
        unique case (w_cfg_idx)
            ssc_pkg::REG_RATE:  prdata = ssc_pkg::APB_DATA_W'(r_cfg_rate);
            ssc_pkg::REG_DIR:   prdata = ssc_pkg::APB_DATA_W'(r_cfg_dir);
            ssc_pkg::REG_STEPS: prdata = ssc_pkg::APB_DATA_W'(r_cfg_steps);
            ssc_pkg::REG_SPLIT: prdata = ssc_pkg::APB_DATA_W'(r_cfg_split);
            ssc_pkg::REG_REP1:  prdata = ssc_pkg::APB_DATA_W'(r_cfg_rep1);
            ssc_pkg::REG_REP2:  prdata = ssc_pkg::APB_DATA_W'(r_cfg_rep2);
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Effective pattern bounds
    // ------------------------------------------------------------------------

    // A step count of zero plays one step; counts above the store are capped.
    always_comb begin
        if (r_cfg_steps == '0) begin
            w_cnt = ssc_pkg::CNT_W'(1);
        end else if (32'(r_cfg_steps) > 32'(ssc_pkg::NUM_STEPS)) begin
            w_cnt = ssc_pkg::CNT_W'(ssc_pkg::NUM_STEPS);
        end else begin
            w_cnt = ssc_pkg::CNT_W'(r_cfg_steps);
        end
    end

    // A split of zero behaves as a split at the first step.
    assign w_split   = (r_cfg_split == '0) ? ssc_pkg::SPLIT_W'(1) : r_cfg_split;
    assign w_cnt_s   = $signed(ssc_pkg::POS_W'(w_cnt));
    assign w_last_s  = w_cnt_s - ssc_pkg::POS_ONE;
    assign w_split_s = $signed(ssc_pkg::POS_W'(w_split));

    // ------------------------------------------------------------------------
    // Edge detection and clock divider / multiplier
    // ------------------------------------------------------------------------

    assign w_clk_edge  = r_in_clk & ~r_prev_clk;
    assign w_rst_edge  = r_in_rst & ~r_prev_rst;
    // A reset edge is handled first, so the divider starts from zero.
    assign w_div_base  = w_rst_edge ? '0 : r_div_cnt;
    assign w_div_inc   = {1'b0, w_div_base} + ssc_pkg::ADV_W'(1);
    assign w_div_limit = ssc_pkg::DIV_MAX >> r_cfg_rate[1:0];

    always_comb begin
        if (r_cfg_rate <= ssc_pkg::MODE_DIV_LAST) begin
            if (w_div_inc >= w_div_limit) begin
                w_div_next = '0;
                w_adv_num  = ssc_pkg::ADV_W'(1);
            end else begin
                w_div_next = w_div_inc[ssc_pkg::DIV_W-1:0];
                w_adv_num  = '0;
            end
        end else if (r_cfg_rate >= ssc_pkg::MODE_MUL_FIRST &&
                     r_cfg_rate <= ssc_pkg::MODE_MUL_LAST) begin
            w_div_next = w_div_base;
            w_adv_num  = ssc_pkg::ADV_W'(1) << (r_cfg_rate - ssc_pkg::MODE_X1);
        end else begin
            // Unity rate, including the unused mode codes.
            w_div_next = '0;
            w_adv_num  = ssc_pkg::ADV_W'(1);
        end
    end

    // ------------------------------------------------------------------------
    // Advance unit: one step of play per use
    // ------------------------------------------------------------------------

    assign w_inc = r_position + ssc_pkg::POS_ONE;
    assign w_dec = r_position - ssc_pkg::POS_ONE;
    assign w_fc  = {1'b0, r_frc} + (ssc_pkg::REP_W+1)'(1);
    assign w_sc  = {1'b0, r_src} + (ssc_pkg::REP_W+1)'(1);

    always_comb begin
        a_pos       = r_position;
        a_up        = r_up;
        a_frc       = r_frc;
        a_src       = r_src;
        a_in_second = r_in_second;
        if (r_cfg_dir == ssc_pkg::DIR_FWD) begin
            a_pos = w_inc;
            if (!r_in_second) begin
                // End of the first section: repeat it or move on.
                if (w_inc >= w_split_s) begin
                    if (w_fc >= {1'b0, r_cfg_rep1}) begin
                        a_in_second = 1'b1;
                        a_frc       = '0;
                    end else begin
                        a_frc = w_fc[ssc_pkg::REP_W-1:0];
                        a_pos = ssc_pkg::POS_ZERO;
                    end
                end
            end else if (w_inc >= w_cnt_s) begin
                // End of the second section.
                if (w_sc >= {1'b0, r_cfg_rep2}) begin
                    a_in_second = 1'b0;
                    a_src       = '0;
                    a_pos       = ssc_pkg::POS_ZERO;
                end else begin
                    a_src = w_sc[ssc_pkg::REP_W-1:0];
                    a_pos = w_split_s;
                end
            end
        end else if (r_cfg_dir == ssc_pkg::DIR_BWD) begin
            a_pos = w_dec;
            if (r_in_second) begin
                // Fell below the split: repeat the second section or leave it.
                if (w_dec < w_split_s) begin
                    if (w_sc >= {1'b0, r_cfg_rep2}) begin
                        a_in_second = 1'b0;
                        a_src       = '0;
                    end else begin
                        a_src = w_sc[ssc_pkg::REP_W-1:0];
                        a_pos = w_last_s;
                    end
                end
            end else if (w_dec < ssc_pkg::POS_ZERO) begin
                // Fell below step zero.
                if (w_fc >= {1'b0, r_cfg_rep1}) begin
                    a_in_second = 1'b1;
                    a_frc       = '0;
                    a_pos       = w_last_s;
                end else begin
                    a_frc = w_fc[ssc_pkg::REP_W-1:0];
                    a_pos = w_split_s - ssc_pkg::POS_ONE;
                end
            end
        end else begin
            // Ping-pong, also for the unused direction code.
            if (r_up) begin
                a_pos = w_inc;
                if (w_inc >= w_cnt_s) begin
                    a_pos = w_last_s;
                    a_up  = 1'b0;
                end
            end else begin
                a_pos = w_dec;
                if (w_dec <= ssc_pkg::POS_ZERO) begin
                    a_pos = ssc_pkg::POS_ZERO;
                    a_up  = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Position clamp and pattern memories
    // ------------------------------------------------------------------------

    always_comb begin
        w_clamp_pos = r_position;
        if (w_clamp_pos >= w_cnt_s) begin
            w_clamp_pos = w_last_s;
        end
        if (w_clamp_pos < ssc_pkg::POS_ZERO) begin
            w_clamp_pos = ssc_pkg::POS_ZERO;
        end
    end

    assign w_rd_addr = w_clamp_pos[ssc_pkg::STEP_W-1:0];
    assign w_wr_addr = ssc_pkg::STEP_W'(r_in_step);
    assign w_wr_item = (r_state == S_PROC) && (r_in_func == ssc_pkg::FUNC_WRITE) &&
                       (32'(r_in_step) < 32'(ssc_pkg::NUM_STEPS));

    for (genvar l = 0; l < ssc_pkg::NUM_LANES; l++) begin : g_lane
        logic [ssc_pkg::LEVEL_W-1:0]   r_mem [ssc_pkg::NUM_STEPS];
        logic [ssc_pkg::NUM_STEPS-1:0] r_valid;
        logic [ssc_pkg::LEVEL_W-1:0]   r_rd_data;
        logic                          r_rd_valid;
        logic                          w_we;

        assign w_we = w_wr_item && (32'(r_in_lane) == 32'(l));

        // Pattern entries: written by write items, read once the position settles.
        always_ff @(posedge i_clk) begin
            if (w_we) begin
                r_mem[w_wr_addr] <= r_in_value ^ ssc_pkg::LEVEL_FLIP;
            end
            if (r_state == S_CLAMP) begin
                r_rd_data <= r_mem[w_rd_addr];
            end
        end

        // An entry never written reads as the lane's test level.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid    <= '0;
                r_rd_valid <= 1'b0;
            end else begin
                if (w_we) begin
                    r_valid[w_wr_addr] <= 1'b1;
                end
                if (r_state == S_CLAMP) begin
                    r_rd_valid <= r_valid[w_rd_addr];
                end
            end
        end

        assign w_lane_level[l] = r_rd_valid ? r_rd_data :
                                 ssc_pkg::lane_reset_level(l);
    end

    // Result lanes beyond the stored lanes read as zero.
    for (genvar o = 0; o < ssc_pkg::OUT_LANES; o++) begin : g_out
        if (o < ssc_pkg::NUM_LANES) begin : g_used
            assign w_out_level[o] = w_lane_level[o];
        end else begin : g_absent
            assign w_out_level[o] = '0;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------

    always_comb begin
        n_state     = r_state;
        n_position  = r_position;
        n_up        = r_up;
        n_div_cnt   = r_div_cnt;
        n_frc       = r_frc;
        n_src       = r_src;
        n_in_second = r_in_second;
        n_prev_clk  = r_prev_clk;
        n_prev_rst  = r_prev_rst;
        n_adv_left  = r_adv_left;
        n_in_func   = r_in_func;
        n_in_clk    = r_in_clk;
        n_in_rst    = r_in_rst;
        n_in_step   = r_in_step;
        n_in_lane   = r_in_lane;
        n_in_value  = r_in_value;
        n_out_valid = r_out_valid;
        n_out_pos   = r_out_pos;
        n_out_sec   = r_out_sec;
        n_out_level = r_out_level;

        // A taken result frees the output register.
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_in_func  = ssc_pkg::t_func'(s_axis_tuser[0]);
                    n_in_clk   = s_axis_tdata[0];
                    n_in_rst   = s_axis_tdata[1];
                    n_in_step  = s_axis_tdata[6:2];
                    n_in_lane  = s_axis_tdata[8:7];
                    n_in_value = s_axis_tdata[24:9];
                    n_state    = S_PROC;
                end
            end
            S_PROC: begin
                // Ticks update edge history, handle reset, then the clock edge.
                if (r_in_func == ssc_pkg::FUNC_TICK) begin
                    n_prev_clk = r_in_clk;
                    n_prev_rst = r_in_rst;
                    if (w_rst_edge) begin
                        n_position  = ssc_pkg::POS_ZERO;
                        n_up        = 1'b1;
                        n_frc       = '0;
                        n_src       = '0;
                        n_in_second = 1'b0;
                    end
                    n_div_cnt  = w_clk_edge ? w_div_next : w_div_base;
                    n_adv_left = w_clk_edge ? w_adv_num : '0;
                end else begin
                    n_adv_left = '0;
                end
                n_state = S_ADV;
            end
            S_ADV: begin
                if (r_adv_left == '0) begin
                    n_state = S_CLAMP;
                end else begin
                    n_position  = a_pos;
                    n_up        = a_up;
                    n_frc       = a_frc;
                    n_src       = a_src;
                    n_in_second = a_in_second;
                    n_adv_left  = r_adv_left - ssc_pkg::ADV_W'(1);
                end
            end
            S_CLAMP: begin
                n_position = w_clamp_pos;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = ssc_pkg::FIELD_POS_W'(r_position);
                    n_out_sec   = r_in_second;
                    n_out_level = w_out_level;
                    n_state     = S_IDLE;
                end
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_position  <= ssc_pkg::POS_ZERO;
            r_up        <= 1'b1;
            r_div_cnt   <= '0;
            r_frc       <= '0;
            r_src       <= '0;
            r_in_second <= 1'b0;
            r_prev_clk  <= 1'b0;
            r_prev_rst  <= 1'b0;
            r_adv_left  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_position  <= n_position;
            r_up        <= n_up;
            r_div_cnt   <= n_div_cnt;
            r_frc       <= n_frc;
            r_src       <= n_src;
            r_in_second <= n_in_second;
            r_prev_clk  <= n_prev_clk;
            r_prev_rst  <= n_prev_rst;
            r_adv_left  <= n_adv_left;
            r_out_valid <= n_out_valid;
        end
        r_in_func   <= n_in_func;
        r_in_clk    <= n_in_clk;
        r_in_rst    <= n_in_rst;
        r_in_step   <= n_in_step;
        r_in_lane   <= n_in_lane;
        r_in_value  <= n_in_value;
        r_out_pos   <= n_out_pos;
        r_out_sec   <= n_out_sec;
        r_out_level <= n_out_level;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_level[2], r_out_level[1], r_out_level[0],
                            r_out_sec, r_out_pos};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    `SSC_ASSERT_NEXT(a_one_item_at_a_time, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "input accepted while an item is still in progress")

    `SSC_ASSERT_IMPLY(a_clamped_position, i_clk, i_rst_n,
        r_state == S_LOAD, r_position >= ssc_pkg::POS_ZERO && r_position < w_cnt_s,
        "position outside the active steps after the clamp")

    `SSC_ASSERT_IMPLY(a_advance_bound, i_clk, i_rst_n,
        r_state == S_ADV, r_adv_left <= ssc_pkg::MAX_ADV,
        "more advances pending than the fastest rate allows")

    `SSC_ASSERT_NEXT(a_section_held, i_clk, i_rst_n,
        r_state != S_PROC && r_state != S_ADV, r_in_second == $past(r_in_second),
        "section changed outside reset handling or advancing")

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Step sequencer channel testbench
// Drives tick and step-write transactions into the channel through its input
// stream and checks every result against a cycle-free model of the channel
// (clock divider and multiplier, two-section and ping-pong play, clamp and
// pattern store). Registers are written over the configuration port between
// phases. A short directed table comes first, then random phases with
// different idling on both streams and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ssc_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASE_ITEMS    = 100;
    localparam int NUM_PHASES     = 8;

    // Codes used by the stimulus that the package gives no name to.
    localparam logic [RATE_W-1:0]     MODE_DIV16   = 4'd0;
    localparam logic [RATE_W-1:0]     MODE_OOR     = 4'd15;
    localparam logic [DIR_W-1:0]      DIR_ALT_PING = 2'd3;
    localparam logic [LANE_SEL_W-1:0] LANE_ABSENT  = 2'd3;

    typedef struct packed {
        t_func           func;
        logic            clk_lvl;
        logic            rst_lvl;
        logic [4:0]      wstep;
        logic [1:0]      wlane;
        logic [15:0]     wval;
    } item_t;

    typedef struct packed {
        logic [4:0]  pos;
        logic        sec;
        logic [15:0] lvl_a;
        logic [15:0] lvl_b;
        logic [15:0] lvl_c;
    } result_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        t_reg_idx  reg_idx;
        logic [6:0] reg_val;
        item_t     item;
        logic      typed;
        result_t   res;
    } row_t;

    // Ticks with the four combinations of clock and reset levels.
    localparam item_t TICK_LO     = '{FUNC_TICK, 1'b0, 1'b0, 5'd0, 2'd0, 16'd0};
    localparam item_t TICK_HI     = '{FUNC_TICK, 1'b1, 1'b0, 5'd0, 2'd0, 16'd0};
    localparam item_t TICK_RST_LO = '{FUNC_TICK, 1'b0, 1'b1, 5'd0, 2'd0, 16'd0};
    localparam item_t TICK_RST_HI = '{FUNC_TICK, 1'b1, 1'b1, 5'd0, 2'd0, 16'd0};

    // Results that follow directly from the reset pattern and the extremes.
    localparam result_t RES_NONE  = '0;
    localparam result_t RES_RESET = '{5'd0, 1'b0, 16'd13107, 16'd26214, 16'd39321};
    localparam result_t RES_STEP1 = '{5'd1, 1'b0, 16'd13107, 16'd26214, 16'd39321};
    localparam result_t RES_MIN_A = '{5'd1, 1'b0, 16'h0000, 16'd26214, 16'd39321};
    localparam result_t RES_MAX_B = '{5'd1, 1'b0, 16'h0000, 16'hFFFF, 16'd39321};

    localparam int NUM_ROWS = 44;
    localparam row_t DIRECTED [NUM_ROWS] = '{
        // Reset state, one clock edge, then extreme writes at the playing step.
        '{ROW_ITEM, REG_RATE, 7'd0, TICK_LO, 1'b1, RES_RESET},
        '{ROW_ITEM, REG_RATE, 7'd0, TICK_HI, 1'b1, RES_STEP1},
        '{ROW_ITEM, REG_RATE, 7'd0,
          '{FUNC_WRITE, 1'b0, 1'b0, 5'd1, 2'd0, 16'h8000}, 1'b1, RES_MIN_A},
        '{ROW_ITEM, REG_RATE, 7'd0,
          '{FUNC_WRITE, 1'b0, 1'b0, 5'd1, 2'd1, 16'h7FFF}, 1'b1, RES_MAX_B},
        '{ROW_ITEM, REG_RATE, 7'd0,
          '{FUNC_WRITE, 1'b0, 1'b0, 5'd1, LANE_ABSENT, 16'h1234}, 1'b1, RES_MAX_B},
        '{ROW_ITEM, REG_RATE, 7'd0,
          '{FUNC_WRITE, 1'b1, 1'b1, 5'd31, 2'd2, 16'h0000}, 1'b0, RES_NONE},
        '{ROW_ITEM, REG_RATE, 7'd0, TICK_RST_LO, 1'b1, RES_RESET},
        '{ROW_ITEM, REG_RATE, 7'd0, TICK_RST_HI, 1'b0, RES_NONE},
        // Fastest multiply with the spare direction code over five steps.
        '{ROW_CFG, REG_RATE, 7'(MODE_MUL_LAST), TICK_LO, 1'b0, RES_NONE},
        '{ROW_CFG, REG_DIR, 7'(DIR_ALT_PING), TICK_LO, 1'b0, RES_NONE},
        '{ROW_CFG, REG_STEPS, 7'd5, TICK_LO, 1'b0, RES_NONE},
        '{ROW_ITEM, REG_RATE, 7'd0, TICK_LO, 1'b0, RES_NONE},
        '{ROW_ITEM, REG_RATE, 7'd0, TICK_HI, 1'b0, RES_NONE},
        '{ROW_ITEM, REG_RATE, 7'd0, TICK_LO, 1'b0, RES_NONE},
        '{ROW_ITEM, REG_RATE, 7'd0, TICK_HI, 1'b0, RES_NONE},
        // Slowest divide, backwards, zero step count, zero split, zero first repeats, 99 second repeats.
        '{ROW_CFG, REG_RATE, 7'(MODE_DIV16), TICK_LO, 1'b0, RES_NONE},
        '{ROW_CFG, REG_DIR, 7'(DIR_BWD), TICK_LO, 1'b0, RES_NONE},
        '{ROW_CFG, REG_STEPS, 7'd0, TICK_LO, 1'b0, RES_NONE},
        '{ROW_CFG, REG_SPLIT, 7'd0, TICK_LO, 1'b0, RES_NONE},
        '{ROW_CFG, REG_REP1, 7'd0, TICK_LO, 1'b0, RES_NONE},
        '{ROW_CFG, REG_REP2, 7'd99, TICK_LO, 1'b0, RES_NONE},
        '{ROW_ITEM, REG_RATE, 7'd0, TICK_LO, 1'b0, RES_NONE},
        '{ROW_ITEM, REG_RATE, 7'd0, TICK_HI, 1'b0, RES_NONE},
        // Rate code past the table, step count past the store, widest split.
        '{ROW_CFG, REG_RATE, 7'(MODE_OOR), TICK_LO, 1'b0, RES_NONE},
        '{ROW_CFG, REG_STEPS, 7'd63, TICK_LO, 1'b0, RES_NONE},
        '{ROW_CFG, REG_SPLIT, 7'd31, TICK_LO, 1'b0, RES_NONE},
        '{ROW_CFG, REG_REP1, 7'd99, TICK_LO, 1'b0, RES_NONE},
        '{ROW_CFG, REG_REP2, 7'd0, TICK_LO, 1'b0, RES_NONE},
        '{ROW_ITEM, REG_RATE, 7'd0, TICK_LO, 1'b0, RES_NONE},
        '{ROW_ITEM, REG_RATE, 7'd0, TICK_HI, 1'b0, RES_NONE},
        '{ROW_ITEM, REG_RATE, 7'd0, TICK_LO, 1'b0, RES_NONE},
        '{ROW_ITEM, REG_RATE, 7'd0, TICK_HI, 1'b0, RES_NONE},
        // One step in use with the split beyond it, forwards at double rate.
        '{ROW_CFG, REG_RATE, 7'(MODE_MUL_FIRST), TICK_LO, 1'b0, RES_NONE},
        '{ROW_CFG, REG_DIR, 7'(DIR_FWD), TICK_LO, 1'b0, RES_NONE},
        '{ROW_CFG, REG_STEPS, 7'd1, TICK_LO, 1'b0, RES_NONE},
        '{ROW_ITEM, REG_RATE, 7'd0, TICK_LO, 1'b0, RES_NONE},
        '{ROW_ITEM, REG_RATE, 7'd0, TICK_HI, 1'b0, RES_NONE},
        '{ROW_ITEM, REG_RATE, 7'd0,
          '{FUNC_WRITE, 1'b0, 1'b1, 5'd0, 2'd2, 16'h5A5A}, 1'b0, RES_NONE},
        // Ping-pong over the smallest bounce.
        '{ROW_CFG, REG_DIR, 7'(DIR_PING), TICK_LO, 1'b0, RES_NONE},
        '{ROW_CFG, REG_STEPS, 7'd2, TICK_LO, 1'b0, RES_NONE},
        '{ROW_ITEM, REG_RATE, 7'd0, TICK_LO, 1'b0, RES_NONE},
        '{ROW_ITEM, REG_RATE, 7'd0, TICK_HI, 1'b0, RES_NONE},
        '{ROW_ITEM, REG_RATE, 7'd0, TICK_LO, 1'b0, RES_NONE},
        '{ROW_ITEM, REG_RATE, 7'd0, TICK_HI, 1'b0, RES_NONE}
    };

    // Block ports.
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [0:0]             s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr         = '0;
    logic [APB_DATA_W-1:0]  pwdata        = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // Channel model state and its copy of the registers.
    logic [RATE_W-1:0]  cfg_rate;
    logic [DIR_W-1:0]   cfg_dir;
    logic [STEPS_W-1:0] cfg_steps;
    logic [SPLIT_W-1:0] cfg_split;
    logic [REP_W-1:0]   cfg_rep1;
    logic [REP_W-1:0]   cfg_rep2;
    int                 play_pos;
    bit                 pp_up;
    int unsigned        div_cnt;
    int unsigned        rep1_cnt;
    int unsigned        rep2_cnt;
    bit                 in_sec;
    bit                 prev_clk;
    bit                 prev_rst;
    logic [LEVEL_W-1:0] step_levels [NUM_STEPS*NUM_LANES];

    result_t pending_outputs [$];
    int      mismatches = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    bit      hold_req = 1'b0;
    int      hold_left = 0;

    step_sequencer_channel u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock generation.
    always begin
        #10 i_clk = ~i_clk;
    end

    // Step count actually played: zero plays one step, overflow plays them all.
    function automatic int active_steps();
        if (cfg_steps < 1) begin
            return 1;
        end
        if (cfg_steps > NUM_STEPS) begin
            return NUM_STEPS;
        end
        return int'(cfg_steps);
    endfunction

    // Returns the play position to the start and clears the counters.
    function automatic void restart_play();
        play_pos = 0;
        pp_up    = 1'b1;
        div_cnt  = 0;
        rep1_cnt = 0;
        rep2_cnt = 0;
        in_sec   = 1'b0;
    endfunction

    // One move of the play position, without the final clamp.
    function automatic void advance_position();
        int          cnt;
        int          split;
        int unsigned r1;
        int unsigned r2;
        cnt   = active_steps();
        split = (cfg_split < 1) ? 1 : int'(cfg_split);
        r1    = cfg_rep1;
        r2    = cfg_rep2;
        if (cfg_dir == DIR_FWD) begin
            play_pos++;
            if (!in_sec) begin
                if (play_pos >= split) begin
                    rep1_cnt++;
                    if (rep1_cnt >= r1) begin
                        in_sec   = 1'b1;
                        rep1_cnt = 0;
                    end else begin
                        play_pos = 0;
                    end
                end
            end else if (play_pos >= cnt) begin
                rep2_cnt++;
                if (rep2_cnt >= r2) begin
                    in_sec   = 1'b0;
                    rep2_cnt = 0;
                    play_pos = 0;
                end else begin
                    play_pos = split;
                end
            end
        end else if (cfg_dir == DIR_BWD) begin
            play_pos--;
            if (in_sec) begin
                if (play_pos < split) begin
                    rep2_cnt++;
                    if (rep2_cnt >= r2) begin
                        in_sec   = 1'b0;
                        rep2_cnt = 0;
                    end else begin
                        play_pos = cnt - 1;
                    end
                end
            end else if (play_pos < 0) begin
                rep1_cnt++;
                if (rep1_cnt >= r1) begin
                    in_sec   = 1'b1;
                    rep1_cnt = 0;
                    play_pos = cnt - 1;
                end else begin
                    play_pos = split - 1;
                end
            end
        end else begin
            // Ping-pong, also for the spare direction code.
            if (pp_up) begin
                play_pos++;
                if (play_pos >= cnt) begin
                    play_pos = cnt - 1;
                    pp_up    = 1'b0;
                end
            end else begin
                play_pos--;
                if (play_pos <= 0) begin
                    play_pos = 0;
                    pp_up    = 1'b1;
                end
            end
        end
    endfunction

    // Applies one transaction to the model and returns the channel output.
    function automatic result_t next_channel_output(input item_t it);
        bit          clk_edge;
        bit          rst_edge;
        int unsigned n_adv;
        int          cnt;
        int          base;
        result_t     r;
        if (it.func == FUNC_TICK) begin
            clk_edge = it.clk_lvl && !prev_clk;
            rst_edge = it.rst_lvl && !prev_rst;
            prev_clk = it.clk_lvl;
            prev_rst = it.rst_lvl;
            // The reset edge is taken before the clock edge.
            if (rst_edge) begin
                restart_play();
            end
            if (clk_edge) begin
                if (cfg_rate <= MODE_DIV_LAST) begin
                    div_cnt++;
                    if (div_cnt >= (16 >> cfg_rate)) begin
                        div_cnt = 0;
                        advance_position();
                    end
                end else if (cfg_rate >= MODE_MUL_FIRST && cfg_rate <= MODE_MUL_LAST) begin
                    n_adv = 1 << (cfg_rate - MODE_X1);
                    repeat (n_adv) advance_position();
                end else begin
                    // Unity rate, and every code past the multiply range.
                    div_cnt = 0;
                    advance_position();
                end
            end
        end else if (it.wstep < NUM_STEPS && it.wlane < NUM_LANES) begin
            step_levels[int'(it.wstep) * NUM_LANES + int'(it.wlane)] = it.wval ^ LEVEL_FLIP;
        end
        // Clamp below the step count, writes included.
        cnt = active_steps();
        if (play_pos >= cnt) begin
            play_pos = cnt - 1;
        end
        if (play_pos < 0) begin
            play_pos = 0;
        end
        base    = play_pos * NUM_LANES;
        r.pos   = play_pos[4:0];
        r.sec   = in_sec;
        r.lvl_a = step_levels[base];
        r.lvl_b = (NUM_LANES > 1) ? step_levels[base + 1] : '0;
        r.lvl_c = (NUM_LANES > 2) ? step_levels[base + 2] : '0;
        return r;
    endfunction

    // Offers one transaction after a random gap and records what it must produce.
    task automatic send_item(input item_t it, input logic typed, input result_t typed_res);
        result_t predicted;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, it.wval, it.wlane, it.wstep, it.rst_lvl, it.clk_lvl};
        s_axis_tuser  <= it.func;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = next_channel_output(it);
        pending_outputs.push_back(typed ? typed_res : predicted);
        @(negedge i_clk);
    endtask

    // Stops offering and waits until every outstanding result has arrived.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending_outputs.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // One register write: setup, access, then back to idle.
    task automatic apb_write(input t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_RATE:  cfg_rate  = val[RATE_W-1:0];
            REG_DIR:   cfg_dir   = val[DIR_W-1:0];
            REG_STEPS: cfg_steps = val[STEPS_W-1:0];
            REG_SPLIT: cfg_split = val[SPLIT_W-1:0];
            REG_REP1:  cfg_rep1  = val[REP_W-1:0];
            REG_REP2:  cfg_rep2  = val[REP_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Result receiver: random stalls, and a long hold-off when asked for.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_outputs.size() == 0) begin
                $error("result 0x%0h arrived with no transaction outstanding", m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_outputs.pop_front();
                if (m_axis_tdata[4:0] !== want.pos) begin
                    $error("current_position: expected %0d, got %0d",
                           want.pos, m_axis_tdata[4:0]);
                    mismatches++;
                end
                if (m_axis_tdata[5] !== want.sec) begin
                    $error("second_section_active: expected %0d, got %0d",
                           want.sec, m_axis_tdata[5]);
                    mismatches++;
                end
                if (m_axis_tdata[21:6] !== want.lvl_a) begin
                    $error("level_a: expected %0d, got %0d", want.lvl_a, m_axis_tdata[21:6]);
                    mismatches++;
                end
                if (m_axis_tdata[37:22] !== want.lvl_b) begin
                    $error("level_b: expected %0d, got %0d", want.lvl_b, m_axis_tdata[37:22]);
                    mismatches++;
                end
                if (m_axis_tdata[53:38] !== want.lvl_c) begin
                    $error("level_c: expected %0d, got %0d", want.lvl_c, m_axis_tdata[53:38]);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: ends the run when nothing has moved for too long.
    initial begin : watchdog
        int quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (psel && penable)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial begin
        item_t       it;
        int          roll;
        int          steps_pick;
        int          split_top;
        bit          last_clk;
        logic [31:0] v;

        // Model state after reset.
        cfg_rate  = RATE_RST;
        cfg_dir   = DIR_RST;
        cfg_steps = STEPS_RST;
        cfg_split = SPLIT_RST;
        cfg_rep1  = REP_RST;
        cfg_rep2  = REP_RST;
        restart_play();
        prev_clk = 1'b0;
        prev_rst = 1'b0;
        for (int s = 0; s < NUM_STEPS; s++) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                v = 32'd13107 * 32'(l + 1);
                step_levels[s * NUM_LANES + l] = (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
            end
        end

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table; register rows wait for the channel to go quiet.
        for (int i = 0; i < NUM_ROWS; i++) begin
            if (DIRECTED[i].kind == ROW_CFG) begin
                settle();
                apb_write(DIRECTED[i].reg_idx, 32'(DIRECTED[i].reg_val));
            end else begin
                send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].res);
            end
        end
        last_clk = 1'b1;

        // Random phases, each with its own settings and idling pattern.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            apb_write(REG_RATE, 32'($urandom_range(15)));
            apb_write(REG_DIR, 32'($urandom_range(3)));
            steps_pick = ($urandom_range(99) < 20) ? $urandom_range(63) : $urandom_range(1, 12);
            apb_write(REG_STEPS, 32'(steps_pick));
            split_top = (steps_pick > 31) ? 31 : steps_pick;
            apb_write(REG_SPLIT, ($urandom_range(99) < 20) ? $urandom_range(31)
                                                            : $urandom_range(split_top));
            apb_write(REG_REP1, ($urandom_range(99) < 15) ? $urandom_range(127)
                                                           : $urandom_range(3));
            apb_write(REG_REP2, ($urandom_range(99) < 15) ? $urandom_range(127)
                                                           : $urandom_range(3));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            // Long receiver hold-off while the sender keeps offering.
            if (ph == 4) begin
                hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll     = $urandom_range(99);
                it.wstep = $urandom_range(31);
                it.wlane = $urandom_range(3);
                it.wval  = $urandom_range(16'hFFFF);
                if (roll < 12) begin
                    it.func    = FUNC_WRITE;
                    it.clk_lvl = $urandom_range(1);
                    it.rst_lvl = $urandom_range(1);
                end else begin
                    // Mostly a clean clock square wave, now and then a glitch.
                    it.func    = FUNC_TICK;
                    it.clk_lvl = (roll < 20) ? $urandom_range(1) : !last_clk;
                    it.rst_lvl = ($urandom_range(99) < 4);
                    last_clk   = it.clk_lvl;
                end
                send_item(it, 1'b0, RES_NONE);
            end
        end

        // Drain and give the block time to show any stray result.
        settle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
